### rtl/ett_pkg.sv
// Shared constants, request and result types for the epoch tag table.
package ett_pkg;

   // Table geometry
   localparam int ENTRIES     = 1024;
   localparam int COUNT_WIDTH = 16;
   localparam int ADDR_WIDTH  = $clog2(ENTRIES);
   localparam int SUM_WIDTH   = COUNT_WIDTH + 2;

   // Command queue between front and back
   localparam int FIFO_DEPTH  = 4;
   localparam int PTR_WIDTH   = $clog2(FIFO_DEPTH);
   localparam int LVL_WIDTH   = $clog2(FIFO_DEPTH + 1);

   // Request opcodes
   localparam logic [1:0] OP_SET_TAG   = 2'd0;
   localparam logic [1:0] OP_READ_TAG  = 2'd1;
   localparam logic [1:0] OP_UNTAG     = 2'd2;
   localparam logic [1:0] OP_UNTAG_NEW = 2'd3;

   localparam logic [7:0] TAG_SAT = 8'hFF;

   typedef struct packed {
      logic [1:0] opcode;
      logic [9:0] entry_index;
      logic [7:0] tag_value;
      logic [7:0] new_range;
   } req_type;

   typedef struct packed {
      logic [7:0] tag_out;
      logic       tagged_res;
      logic       overflow_cleared;
   } rsp_type;

   // What the back end has to do for one request
   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_READ,
      CMD_REPORT,
      CMD_CLEAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [ADDR_WIDTH-1:0]   addr;
      logic [COUNT_WIDTH-1:0]  word;   // stored word for a write, base for a read
   } cmd_type;

   typedef enum logic {
      BK_SWEEP,
      BK_RUN
   } bk_state_type;

   // Back end status towards the top level
   typedef struct packed {
      logic init_busy;
      logic pop;
   } bk_status_type;

endpackage

### rtl/ett_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ett_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ett_front.sv
// Front end: holds base and range, classifies each request into a command.
module ett_front
   import ett_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req_data,
   output logic    push,
   output cmd_type cmd
);

   logic [COUNT_WIDTH-1:0] base_ff;
   logic [COUNT_WIDTH-1:0] base_in;
   logic [7:0]             range_ff;
   logic [7:0]             range_in;
   logic [7:0]             adv_range;
   logic [SUM_WIDTH-1:0]   probe;
   logic                   fits;
   logic                   in_range;

   assign in_range = 32'(req_data.entry_index) < ENTRIES;

   // Range used for the advance: a larger new range applies before advancing
   assign adv_range = (req_data.opcode == OP_UNTAG_NEW && req_data.new_range > range_ff)
                      ? req_data.new_range : range_ff;

   assign probe = SUM_WIDTH'(base_ff) + (SUM_WIDTH'(adv_range) << 1);
   assign fits  = probe < SUM_WIDTH'({COUNT_WIDTH{1'b1}});

   // Classify the request and work out the next base and range
   always_comb begin
      base_in   = base_ff;
      range_in  = range_ff;
      cmd.kind  = CMD_REPORT;
      cmd.addr  = ADDR_WIDTH'(req_data.entry_index);
      cmd.word  = base_ff;
      unique case (req_data.opcode)
         OP_SET_TAG: begin
            cmd.kind = in_range ? CMD_WRITE : CMD_REPORT;
            cmd.word = base_ff + COUNT_WIDTH'(req_data.tag_value);
         end
         OP_READ_TAG: begin
            cmd.kind = in_range ? CMD_READ : CMD_REPORT;
         end
         OP_UNTAG, OP_UNTAG_NEW: begin
            if (fits) begin
               base_in  = base_ff + COUNT_WIDTH'(adv_range);
               cmd.kind = CMD_REPORT;
            end else begin
               base_in  = '0;
               cmd.kind = CMD_CLEAR;
            end
            if (req_data.opcode == OP_UNTAG_NEW) begin
               range_in = req_data.new_range;
            end
         end
         default: begin
            cmd.kind = CMD_REPORT;
         end
      endcase
   end

   assign push = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         range_ff <= 8'd1;
      end else if (accept) begin
         base_ff  <= base_in;
         range_ff <= range_in;
      end
   end

endmodule

### rtl/ett_fifo.sv
// Short command queue between front end and back end.
module ett_fifo
   import ett_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty,
   output logic    full
);

   cmd_type              slot_ff [FIFO_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff;
   logic [PTR_WIDTH-1:0] rd_ptr_ff;
   logic [LVL_WIDTH-1:0] level_ff;
   logic [LVL_WIDTH-1:0] level_in;

   assign empty    = level_ff == '0;
   assign full     = level_ff == LVL_WIDTH'(FIFO_DEPTH);
   assign pop_data = slot_ff[rd_ptr_ff];

   // Fill level follows pushes and pops
   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         level_ff <= level_in;
      end
   end

endmodule

### rtl/ett_back.sv
// Back end: carries out commands on the tag store and forms the results.
module ett_back
   import ett_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          empty,
   input  cmd_type       cmd,
   output bk_status_type status,
   output logic          rsp_valid,
   output rsp_type       rsp_data
);

   bk_state_type           state_ff;
   bk_state_type           state_in;
   logic [ADDR_WIDTH-1:0]  sweep_addr_ff;
   logic                   sweep_last;
   logic                   init_ff;
   logic                   pop;

   logic                   wr_en;
   logic [ADDR_WIDTH-1:0]  wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic                   rd_en;
   logic [COUNT_WIDTH-1:0] rd_data;

   logic                   s2_valid_ff;
   logic                   s2_read_ff;
   logic                   s2_clear_ff;
   logic [COUNT_WIDTH-1:0] s2_base_ff;

   logic [COUNT_WIDTH-1:0] diff;
   logic                   hit;
   rsp_type                rsp_in;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   assign sweep_last = sweep_addr_ff == ADDR_WIDTH'(ENTRIES - 1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_SWEEP: begin
            if (sweep_last) begin
               state_in = BK_RUN;
            end
         end
         BK_RUN: begin
            if (!empty && cmd.kind == CMD_CLEAR) begin
               state_in = BK_SWEEP;
            end
         end
         default: state_in = BK_RUN;
      endcase
   end

   // Store access per state
   always_comb begin
      pop     = 1'b0;
      wr_en   = 1'b0;
      wr_addr = cmd.addr;
      wr_data = cmd.word;
      rd_en   = 1'b0;
      unique case (state_ff)
         BK_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = sweep_addr_ff;
            wr_data = '0;
         end
         BK_RUN: begin
            pop   = !empty;
            wr_en = !empty && cmd.kind == CMD_WRITE;
            rd_en = !empty && cmd.kind == CMD_READ;
         end
         default: pop = 1'b0;
      endcase
   end

   ett_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cmd.addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_SWEEP;
         sweep_addr_ff <= '0;
         init_ff       <= 1'b1;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_SWEEP) begin
            sweep_addr_ff <= sweep_addr_ff + 1'b1;
            if (sweep_last) begin
               init_ff <= 1'b0;
            end
         end else begin
            sweep_addr_ff <= '0;
         end
         s2_valid_ff  <= pop;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // Second stage payload
   always_ff @(posedge clock) begin
      s2_read_ff  <= cmd.kind == CMD_READ;
      s2_clear_ff <= cmd.kind == CMD_CLEAR;
      s2_base_ff  <= cmd.word;
      rsp_ff      <= rsp_in;
   end

   // Read result relative to the base, saturated to the tag width
   assign diff = rd_data - s2_base_ff;
   assign hit  = s2_read_ff && (rd_data > s2_base_ff);

   always_comb begin
      rsp_in.tag_out          = '0;
      rsp_in.tagged_res       = hit;
      rsp_in.overflow_cleared = s2_clear_ff;
      if (hit) begin
         rsp_in.tag_out = (diff > COUNT_WIDTH'(TAG_SAT)) ? TAG_SAT : diff[7:0];
      end
   end

   assign status.init_busy = init_ff;
   assign status.pop       = pop;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;

endmodule

### rtl/epoch_tag_table.sv
// Epoch tag table: per-entry tags with a constant-time untag of all entries.
// A taken request passes through a queue slot, the back end's second stage and the result
// register before its result strobe; one request per cycle is sustained while busy is low.
// An untag that wraps the base sweeps the store to zero, one entry per cycle;
// requests still queue meanwhile and busy rises once the four-deep queue fills.
// After reset busy stays high while the store is swept to zero.
// Results cannot be held off by the receiver.
module epoch_tag_table
   import ett_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic          accept;
   logic          push;
   cmd_type       push_cmd;
   cmd_type       pop_cmd;
   logic          empty;
   logic          full;
   bk_status_type bk_status;

   assign busy   = full || bk_status.init_busy;
   assign accept = start && !busy;

   ett_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (push),
      .cmd      (push_cmd)
   );

   ett_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (bk_status.pop),
      .pop_data  (pop_cmd),
      .empty     (empty),
      .full      (full)
   );

   ett_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .cmd       (pop_cmd),
      .status    (bk_status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/ett_checker.sv
// Port-level checks for the epoch tag table, bound to the top level.
module ett_checker
   import ett_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // Store sweep after reset holds requests off
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   // No result straight after reset
   a_quiet_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // Request fields are known whenever a request is taken
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> !$isunknown(req_data))
      else $error("unknown request fields at accept");

   // A tagged read always carries a nonzero tag, an untagged one a zero tag
   a_tag_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.tagged_res == (rsp_data.tag_out != 8'd0)))
      else $error("tag flag and tag value disagree");

   // A read never reports a store clear
   a_read_or_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.tagged_res && rsp_data.overflow_cleared))
      else $error("tagged read and clear in one result");

endmodule

bind epoch_tag_table ett_checker u_ett_checker (.*);

### tb/sv/epoch_tag_table_test.sv
// Self-checking testbench for the epoch tag table: random and directed requests, scoreboard.
module epoch_tag_table_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ett_pkg::*;

   // Expected behaviour of the table: base, range and stored words, plus results owed
   class epoch_tag_ledger;
      localparam longint COUNT_MAX = (64'd1 << COUNT_WIDTH) - 1;

      logic [COUNT_WIDTH-1:0] base_cnt;
      logic [7:0]             range_cnt;
      logic [COUNT_WIDTH-1:0] tag_words [ENTRIES];
      rsp_type                owed_rsp [$];
      int                     errors;
      int                     n_ops [4];
      int                     n_sweeps;
      int                     n_tagged;

      function new();
         base_cnt  = '0;
         range_cnt = 8'd1;
         foreach (tag_words[i]) tag_words[i] = '0;
         errors    = 0;
         foreach (n_ops[i]) n_ops[i] = 0;
         n_sweeps  = 0;
         n_tagged  = 0;
      endfunction

      // Move the base on by the range, or sweep everything once near the top
      function bit advance_base();
         if (longint'(base_cnt) + 2 * longint'(range_cnt) < COUNT_MAX) begin
            base_cnt = base_cnt + range_cnt;
            return 1'b0;
         end
         base_cnt = '0;
         foreach (tag_words[i]) tag_words[i] = '0;
         return 1'b1;
      endfunction

      // Accepted request: update the state and queue the result it owes
      function void note_request(req_type r);
         rsp_type                exp_rsp;
         logic [COUNT_WIDTH-1:0] diff;
         exp_rsp = '0;
         n_ops[r.opcode]++;
         case (r.opcode)
            OP_SET_TAG: begin
               tag_words[r.entry_index] = base_cnt + r.tag_value;
            end
            OP_READ_TAG: begin
               if (tag_words[r.entry_index] > base_cnt) begin
                  diff = tag_words[r.entry_index] - base_cnt;
                  exp_rsp.tagged_res = 1'b1;
                  exp_rsp.tag_out    = (diff > 255) ? TAG_SAT : diff[7:0];
               end
            end
            OP_UNTAG: begin
               exp_rsp.overflow_cleared = advance_base();
            end
            default: begin
               // shrinking range advances with the old one, growing range first
               if (r.new_range <= range_cnt) begin
                  exp_rsp.overflow_cleared = advance_base();
                  range_cnt = r.new_range;
               end else begin
                  range_cnt = r.new_range;
                  exp_rsp.overflow_cleared = advance_base();
               end
            end
         endcase
         owed_rsp.push_back(exp_rsp);
      endfunction

      // Result strobe: compare with the oldest owed result
      function void check_result(rsp_type got);
         rsp_type exp_rsp;
         if (owed_rsp.size() == 0) begin
            $error("unexpected result: tag_out %0d tagged_res %0b overflow_cleared %0b",
                   got.tag_out, got.tagged_res, got.overflow_cleared);
            errors++;
            return;
         end
         exp_rsp = owed_rsp.pop_front();
         if (got.tag_out !== exp_rsp.tag_out) begin
            $error("tag_out: expected %0d, got %0d", exp_rsp.tag_out, got.tag_out);
            errors++;
         end
         if (got.tagged_res !== exp_rsp.tagged_res) begin
            $error("tagged_res: expected %0b, got %0b", exp_rsp.tagged_res, got.tagged_res);
            errors++;
         end
         if (got.overflow_cleared !== exp_rsp.overflow_cleared) begin
            $error("overflow_cleared: expected %0b, got %0b",
                   exp_rsp.overflow_cleared, got.overflow_cleared);
            errors++;
         end
         if (exp_rsp.overflow_cleared) n_sweeps++;
         if (exp_rsp.tagged_res) n_tagged++;
      endfunction
   endclass

   localparam int RANDOM_ITEMS = 800;
   localparam int STALL_LIMIT  = 20000;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   epoch_tag_ledger ledger = new();

   int              idle_pct;
   int              quiet_left;
   int              n_sent;
   int              stall_cnt;
   logic [9:0]      pool [8];

   epoch_tag_table u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Monitor: requests and results taken at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) ledger.note_request(req_data);
         if (rsp_valid) ledger.check_result(rsp_data);
      end
   end

   // Watchdog on cycles with no traffic at all
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
         $display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cnt <= stall_cnt + 1;
      end
   end

   // Drive one request after a random gap, return once it is taken
   task automatic send_request(input logic [1:0] op, input logic [9:0] idx,
                               input logic [7:0] tag, input logic [7:0] nr);
      req_type r;
      r.opcode      = op;
      r.entry_index = idx;
      r.tag_value   = tag;
      r.new_range   = nr;
      if (quiet_left > 0) quiet_left--;
      else if ($urandom_range(99) < 2) quiet_left = 25;
      if (quiet_left == 0) begin
         while ($urandom_range(99) < idle_pct) begin
            @(negedge clock);
            start = 1'b0;
         end
      end
      @(negedge clock);
      start    = 1'b1;
      req_data = r;
      @(posedge clock);
      while (busy) @(posedge clock);
      n_sent++;
   endtask

   // Short directed run: fresh reads, tag extremes, range shrink and growth
   task automatic directed_requests();
      send_request(OP_READ_TAG,  10'd0,    8'd0,   8'd0);
      send_request(OP_SET_TAG,   10'd0,    8'd0,   8'd255);
      send_request(OP_READ_TAG,  10'd0,    8'd0,   8'd0);
      send_request(OP_SET_TAG,   10'd1023, 8'd255, 8'd0);
      send_request(OP_READ_TAG,  10'd1023, 8'd0,   8'd0);
      send_request(OP_SET_TAG,   10'd5,    8'd1,   8'd0);
      send_request(OP_UNTAG,     10'd0,    8'd0,   8'd0);
      send_request(OP_READ_TAG,  10'd5,    8'd0,   8'd0);
      send_request(OP_READ_TAG,  10'd1023, 8'd0,   8'd0);
      send_request(OP_UNTAG_NEW, 10'd0,    8'd0,   8'd0);
      send_request(OP_UNTAG,     10'd1023, 8'd255, 8'd255);
      send_request(OP_UNTAG_NEW, 10'd0,    8'd0,   8'd255);
      send_request(OP_SET_TAG,   10'd7,    8'd128, 8'd0);
      send_request(OP_READ_TAG,  10'd7,    8'd0,   8'd0);
      send_request(OP_READ_TAG,  10'd1023, 8'd0,   8'd0);
      send_request(OP_UNTAG_NEW, 10'd0,    8'd0,   8'd255);
      send_request(OP_READ_TAG,  10'd7,    8'd0,   8'd0);
      send_request(OP_SET_TAG,   10'd682,  8'd170, 8'd85);
      send_request(OP_READ_TAG,  10'd682,  8'd0,   8'd0);
      send_request(OP_SET_TAG,   10'd341,  8'd85,  8'd170);
      send_request(OP_READ_TAG,  10'd341,  8'd255, 8'd255);
      send_request(OP_UNTAG_NEW, 10'd0,    8'd0,   8'd1);
   endtask

   // One epoch: pick a range, tag and read a few entries, then untag
   task automatic epoch_episode();
      int         n;
      int         pick;
      logic [7:0] rng;
      logic [9:0] idx;
      pick = $urandom_range(9);
      if (pick < 5) rng = 8'($urandom_range(200, 255));
      else if (pick < 8) rng = 8'($urandom_range(0, 15));
      else rng = 8'($urandom_range(0, 255));
      send_request(OP_UNTAG_NEW, 10'($urandom), 8'($urandom), rng);
      n = $urandom_range(4, 12);
      repeat (n) begin
         idx = pool[3'($urandom_range(7))];
         if ($urandom_range(1))
            send_request(OP_SET_TAG, idx,
                         $urandom_range(2) == 0 ? 8'($urandom) : 8'($urandom_range(0, rng)),
                         8'($urandom));
         else
            send_request(OP_READ_TAG, idx, 8'($urandom), 8'($urandom));
      end
      if ($urandom_range(1))
         send_request(OP_UNTAG, 10'($urandom), 8'($urandom), 8'($urandom));
      else
         send_request(OP_UNTAG_NEW, 10'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // Run of untags at a wide range, to push the base over the top
   task automatic untag_burst();
      int n;
      send_request(OP_UNTAG_NEW, 10'($urandom), 8'($urandom), 8'($urandom_range(240, 255)));
      n = $urandom_range(20, 60);
      repeat (n) begin
         case ($urandom_range(7))
            0:       send_request(OP_READ_TAG, pool[3'($urandom_range(7))],
                                  8'($urandom), 8'($urandom));
            1:       send_request(OP_SET_TAG, pool[3'($urandom_range(7))],
                                  8'($urandom), 8'($urandom));
            default: send_request(OP_UNTAG, 10'($urandom), 8'($urandom), 8'($urandom));
         endcase
      end
      send_request(OP_READ_TAG, pool[3'($urandom_range(7))], 8'($urandom), 8'($urandom));
   endtask

   // Unstructured requests
   task automatic noise_requests();
      int n;
      n = $urandom_range(5, 10);
      repeat (n) send_request(2'($urandom_range(3)), 10'($urandom), 8'($urandom),
                              8'($urandom));
   endtask

   initial begin
      int target;
      int pcts [3];
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      idle_pct   = 0;
      quiet_left = 0;
      n_sent     = 0;
      pcts       = '{0, 77, 16};
      foreach (pool[i]) pool[i] = 10'($urandom);
      pool[0] = 10'd0;
      pool[1] = 10'd1023;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed_requests();

      // Random phases with different sender gap rates
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = pcts[ph];
         target   = n_sent + RANDOM_ITEMS / 3;
         while (n_sent < target) begin
            if ($urandom_range(3) == 0) pool[3'($urandom_range(7))] = 10'($urandom);
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5: epoch_episode();
               6, 7, 8:          untag_burst();
               default:          noise_requests();
            endcase
         end
      end

      @(negedge clock);
      start = 1'b0;

      // Drain, then allow a few cycles for stray strobes
      while (ledger.owed_rsp.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Sent %0d requests: %0d set, %0d read, %0d untag, %0d untag with range.",
               n_sent, ledger.n_ops[OP_SET_TAG], ledger.n_ops[OP_READ_TAG],
               ledger.n_ops[OP_UNTAG], ledger.n_ops[OP_UNTAG_NEW]);
      $display("%0d reads came back tagged; %0d untags wrapped the base and swept the store.",
               ledger.n_tagged, ledger.n_sweeps);
      if (ledger.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### epoch_tag_table.f
rtl/ett_pkg.sv
rtl/ett_ram.sv
rtl/ett_front.sv
rtl/ett_fifo.sv
rtl/ett_back.sv
rtl/epoch_tag_table.sv
rtl/ett_checker.sv
tb/sv/epoch_tag_table_test.sv
